// ----- sv/dmarb_pkg.sv -----
// ----------------------------------------------------------------------------
// dmarb_pkg
// Shared constants, types and helpers of the DMA register bank.
// ----------------------------------------------------------------------------
`default_nettype none

package dmarb_pkg;

    localparam int API_WORDS = 4096;
    localparam int MAX_PAGES = 64;
    localparam int CHANNELS  = 4;

    localparam int CH_W  = $clog2(CHANNELS);
    localparam int NP_W  = $clog2(MAX_PAGES + 1);
    localparam int RX_CH = 1;

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_RX    = 2'd2;

    localparam logic [7:0] OFF_CFG   = 8'h00;
    localparam logic [7:0] OFF_OWNER = 8'h02;

    localparam logic [3:0] SUB_PADDR  = 4'h0;
    localparam logic [3:0] SUB_PDEPTH = 4'h2;
    localparam logic [3:0] SUB_API    = 4'h4;
    localparam logic [3:0] SUB_PLEN   = 4'h6;
    localparam logic [3:0] SUB_CTRL   = 4'h8;
    localparam logic [3:0] SUB_COFF   = 4'hA;

    localparam logic [12:0] C_ENABLE   = 13'h0001;
    localparam logic [12:0] C_IDLE     = 13'h0002;
    localparam logic [12:0] C_ONESHOT  = 13'h0004;
    localparam logic [12:0] C_PAGE     = 13'h0010;
    localparam logic [12:0] C_START    = 13'h0040;
    localparam logic [12:0] C_IRQMODE  = 13'h0080;
    localparam logic [12:0] C_IRQSTATE = 13'h0100;
    localparam logic [12:0] C_ERROR    = 13'h0200;
    localparam logic [12:0] C_DIR      = 13'h0400;
    localparam logic [12:0] C_RO       = C_IDLE | C_IRQSTATE | C_ERROR;

    localparam logic [12:0] CTRL_INIT_VAL = 13'h04A2;
    localparam logic [5:0]  CFG_RESET     = 6'h24;
    localparam logic [3:0]  OWNER_RESET   = 4'hF;
    localparam logic [11:0] DARAM_BASE    = 12'h800;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PAGE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pg_status_t;

    typedef struct packed {
        logic [15:0]     total;
        logic [NP_W-1:0] pages;
        logic [10:0]     last_got;
        logic            flip;
    } pg_result_t;

    function automatic logic [6:0] sat_pages(input logic [NP_W-1:0] n);
        if (int'(n) > 127)
            return 7'd127;
        return 7'(n);
    endfunction

endpackage

`default_nettype wire

// ----- sv/dmarb_pager.sv -----
// ----------------------------------------------------------------------------
// dmarb_pager
// Compare/subtract unit draining receive words one page per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dmarb_pager
    import dmarb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] avail,
    input  wire logic [10:0] maxw,
    output pg_status_t       status,
    output pg_result_t       result
);

    logic            busy_reg;
    logic            done_reg;
    logic [15:0]     rem_reg;
    logic [10:0]     maxw_reg;
    logic [15:0]     total_reg;
    logic [NP_W-1:0] np_reg;
    logic [10:0]     last_reg;
    logic            flip_reg;

    logic [10:0]     got;
    logic [NP_W:0]   np_inc;
    logic            last_step;

    always_comb
    begin
        got       = (rem_reg < {5'b0, maxw_reg}) ? rem_reg[10:0] : maxw_reg;
        np_inc    = {1'b0, np_reg} + {{NP_W{1'b0}}, 1'b1};
        last_step = (got == 11'd0) || (got < maxw_reg) || (np_inc >= (NP_W + 1)'(MAX_PAGES));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && last_step)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= avail;
            maxw_reg  <= maxw;
            total_reg <= 16'd0;
            np_reg    <= '0;
            last_reg  <= 11'd0;
            flip_reg  <= 1'b0;
        end
        else if (busy_reg && got != 11'd0)
        begin
            rem_reg   <= rem_reg - {5'b0, got};
            total_reg <= total_reg + {5'b0, got};
            np_reg    <= np_inc[NP_W-1:0];
            last_reg  <= got;
            flip_reg  <= ~flip_reg;
        end
    end

    assign status.busy     = busy_reg;
    assign status.done     = done_reg;
    assign result.total    = total_reg;
    assign result.pages    = np_reg;
    assign result.last_got = last_reg;
    assign result.flip     = flip_reg;

endmodule

`default_nettype wire

// ----- sv/four_channel_dma_register_bank_unit.sv -----
// ----------------------------------------------------------------------------
// four_channel_dma_register_bank_unit
// Register bank of a four-channel DMA controller with a receive event.
//
//   channel | handshake          | fields
//   in      | in_valid/in_stall  | func offset wdata rx_avail_words
//   out     | out_valid/out_stall| rdata irq_level irq_pulse xfer_dest_index
//           |                    | xfer_words xfer_pages daram_word
//
// register access, or a receive that does not run: EXEC, then DONE loads result
// receive request: EXEC, then PAGE for one pager step per page (up to 64) and
//   one closing step when a full page below the cap or an empty receiver ends
//   the burst, then DONE loads the result
// one item at a time; the next item is accepted the cycle after the result loads
// reset (rst_n low, asynchronous) loads all register reset values at once
// a stalled result holds back only the finish of the following item
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_dma_register_bank_unit
    import dmarb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  offset,
    input  wire logic [15:0] wdata,
    input  wire logic [15:0] rx_avail_words,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      rdata,
    output logic             irq_level,
    output logic             irq_pulse,
    output logic [11:0]      xfer_dest_index,
    output logic [15:0]      xfer_words,
    output logic [6:0]       xfer_pages,
    output logic [11:0]      daram_word
);

    state_t state_reg;
    state_t state_next;

    logic [1:0]  func_reg;
    logic [7:0]  off_reg;
    logic [15:0] wdata_reg;
    logic [15:0] avail_reg;

    logic [5:0]  cfg_reg;
    logic [3:0]  owner_reg;
    logic [15:0] paddr_reg  [CHANNELS];
    logic [10:0] pdepth_reg [CHANNELS];
    logic [11:0] api_reg    [CHANNELS];
    logic [11:0] plen_reg   [CHANNELS];
    logic [12:0] ctrl_reg   [CHANNELS];
    logic [11:0] coff_reg   [CHANNELS];

    logic [15:0] res_rdata_reg;
    logic        res_pulse_reg;
    logic [11:0] res_dst_reg;
    logic [15:0] res_words_reg;
    logic [6:0]  res_pages_reg;

    logic        out_valid_reg;
    logic [15:0] rdata_reg;
    logic        irq_level_reg;
    logic        irq_pulse_reg;
    logic [11:0] dst_reg;
    logic [15:0] words_reg;
    logic [6:0]  pages_reg;
    logic [11:0] daram_reg;

    logic            accept;
    logic            exec_go;
    logic            pg_start;
    logic            pg_fin;
    logic            load_out;
    pg_status_t      pg_status;
    pg_result_t      pg_result;

    logic [3:0]      blk;
    logic            ch_hit;
    logic [CH_W-1:0] ch_idx;
    logic [3:0]      sub;
    logic [15:0]     rd_val;

    logic [12:0]     rx_ctrl;
    logic            rx_run;
    logic [10:0]     rx_maxw;
    logic [10:0]     rx_d;
    logic            rx_err;
    logic            rx_go;
    logic [10:0]     rx_maxw_clip;
    logic [12:0]     fin_ctrl;
    logic            any_irq;
    logic [11:0]     daram_val;

    dmarb_pager u_pager (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (pg_start),
        .avail  (avail_reg),
        .maxw   (rx_maxw_clip),
        .status (pg_status),
        .result (pg_result)
    );

    // register decode
    always_comb
    begin
        blk    = off_reg[7:4] - 4'd1;
        ch_hit = (off_reg[7:4] != 4'd0) && (blk < 4'(CHANNELS));
        ch_idx = blk[CH_W-1:0];
        sub    = off_reg[3:0];
        rd_val = 16'd0;
        if (off_reg == OFF_CFG)
            rd_val = {10'd0, cfg_reg};
        else if (off_reg == OFF_OWNER)
            rd_val = {12'd0, owner_reg};
        else if (ch_hit)
        begin
            case (sub)
                SUB_PADDR:  rd_val = paddr_reg[ch_idx];
                SUB_PDEPTH: rd_val = {5'd0, pdepth_reg[ch_idx]};
                SUB_API:    rd_val = {4'd0, api_reg[ch_idx]};
                SUB_PLEN:   rd_val = {4'd0, plen_reg[ch_idx]};
                SUB_CTRL:   rd_val = {3'd0, ctrl_reg[ch_idx] & ~C_START};
                SUB_COFF:   rd_val = {4'd0, coff_reg[ch_idx]};
                default:    rd_val = 16'd0;
            endcase
        end
    end

    // receive request checks
    always_comb
    begin
        rx_ctrl      = ctrl_reg[RX_CH];
        rx_run       = ((rx_ctrl & C_ENABLE) != 13'd0) && ((rx_ctrl & C_DIR) != 13'd0);
        rx_maxw      = plen_reg[RX_CH][11:1];
        rx_d         = api_reg[RX_CH][11:1];
        rx_err       = rx_run && ((rx_maxw == 11'd0) || (int'(rx_d) >= API_WORDS));
        rx_go        = rx_run && !rx_err;
        rx_maxw_clip = rx_maxw;
        if (int'(rx_d) + int'(rx_maxw) > API_WORDS)
            rx_maxw_clip = 11'(API_WORDS - int'(rx_d));
        fin_ctrl = ((rx_ctrl ^ (pg_result.flip ? C_PAGE : 13'd0)) | C_IRQSTATE | C_IDLE)
                   & ~C_START;
        if ((fin_ctrl & C_ONESHOT) != 13'd0)
            fin_ctrl = fin_ctrl & ~C_ENABLE;
    end

    always_comb
    begin
        any_irq = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
            if ((ctrl_reg[i] & C_IRQSTATE) != 13'd0)
                any_irq = 1'b1;
        daram_val = (api_reg[RX_CH] != 12'd0) ? DARAM_BASE + {1'b0, api_reg[RX_CH][11:1]}
                                              : 12'd0;
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_EXEC;
            ST_EXEC:
                if (func_reg == FUNC_RX && rx_go)
                    state_next = ST_PAGE;
                else
                    state_next = ST_DONE;
            ST_PAGE:
                if (pg_status.done)
                    state_next = ST_DONE;
            ST_DONE:
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        accept   = (state_reg == ST_IDLE) && in_valid;
        exec_go  = (state_reg == ST_EXEC);
        pg_start = exec_go && (func_reg == FUNC_RX) && rx_go;
        pg_fin   = (state_reg == ST_PAGE) && pg_status.done;
        load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            off_reg   <= offset;
            wdata_reg <= wdata;
            avail_reg <= rx_avail_words;
        end
    end

    // register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= CFG_RESET;
            owner_reg <= OWNER_RESET;
            for (int i = 0; i < CHANNELS; i++)
            begin
                paddr_reg[i]  <= 16'd0;
                pdepth_reg[i] <= 11'd0;
                api_reg[i]    <= 12'd0;
                plen_reg[i]   <= 12'd0;
                ctrl_reg[i]   <= CTRL_INIT_VAL;
                coff_reg[i]   <= 12'd0;
            end
        end
        else if (exec_go)
        begin
            case (func_reg)
                FUNC_READ:
                    if (off_reg != OFF_CFG && off_reg != OFF_OWNER && ch_hit
                        && sub == SUB_CTRL)
                        ctrl_reg[ch_idx] <= ctrl_reg[ch_idx] & ~(C_IRQSTATE | C_ERROR);
                FUNC_WRITE:
                    if (off_reg == OFF_CFG)
                        cfg_reg <= wdata_reg[5:0];
                    else if (off_reg == OFF_OWNER)
                        owner_reg <= wdata_reg[3:0];
                    else if (ch_hit)
                    begin
                        case (sub)
                            SUB_PADDR:  paddr_reg[ch_idx]  <= wdata_reg;
                            SUB_PDEPTH: pdepth_reg[ch_idx] <= wdata_reg[10:0];
                            SUB_API:    api_reg[ch_idx]    <= wdata_reg[11:0];
                            SUB_PLEN:   plen_reg[ch_idx]   <= wdata_reg[11:0];
                            SUB_CTRL:   ctrl_reg[ch_idx]   <= (wdata_reg[12:0] & ~C_RO)
                                                              | (ctrl_reg[ch_idx] & C_RO);
                            default:    ;
                        endcase
                    end
                FUNC_RX:
                    if (rx_err)
                        ctrl_reg[RX_CH] <= ctrl_reg[RX_CH] | C_ERROR;
                default: ;
            endcase
        end
        else if (pg_fin && pg_result.pages != '0)
        begin
            coff_reg[RX_CH] <= {pg_result.last_got, 1'b0};
            ctrl_reg[RX_CH] <= fin_ctrl;
        end
    end

    // staged result
    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            res_rdata_reg <= (func_reg == FUNC_READ) ? rd_val : 16'd0;
            res_pulse_reg <= 1'b0;
            res_dst_reg   <= 12'd0;
            res_words_reg <= 16'd0;
            res_pages_reg <= 7'd0;
        end
        else if (pg_fin && pg_result.pages != '0)
        begin
            res_pulse_reg <= (fin_ctrl & C_IRQMODE) != 13'd0;
            res_dst_reg   <= {1'b0, rx_d};
            res_words_reg <= pg_result.total;
            res_pages_reg <= sat_pages(pg_result.pages);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rdata_reg     <= res_rdata_reg;
            irq_level_reg <= any_irq;
            irq_pulse_reg <= res_pulse_reg;
            dst_reg       <= res_dst_reg;
            words_reg     <= res_words_reg;
            pages_reg     <= res_pages_reg;
            daram_reg     <= daram_val;
        end
    end

    assign out_valid       = out_valid_reg;
    assign rdata           = rdata_reg;
    assign irq_level       = irq_level_reg;
    assign irq_pulse       = irq_pulse_reg;
    assign xfer_dest_index = dst_reg;
    assign xfer_words      = words_reg;
    assign xfer_pages      = pages_reg;
    assign daram_word      = daram_reg;

    a_pager_done_in_page: assert property (@(posedge clk) disable iff (!rst_n)
        pg_status.done |-> state_reg == ST_PAGE)
        else $error("pager finished outside the paging state");

    a_pager_idle_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> !pg_status.busy)
        else $error("pager busy while no receive item is in work");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result shown without a finished item");

    a_pulse_needs_pages: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && irq_pulse_reg) |-> pages_reg != 7'd0)
        else $error("completion pulse without a drained page");

    a_no_words_no_pages: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pages_reg == 7'd0) |-> (words_reg == 16'd0 && dst_reg == 12'd0))
        else $error("transfer fields set without a transfer");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-channel DMA register bank. A queue of
// register reads, writes and channel 1 receive requests (directed corner
// cases, then setup-and-receive sequences mixed with random traffic) feeds a
// clocked driver. An in-bench model of the register bank predicts every
// result, and a clocked monitor checks each one in order while both sides
// insert random idle and stall bursts.
// ----------------------------------------------------------------------------

module testbench;
    import dmarb_pkg::*;

    localparam logic [1:0] FUNC_NOP    = 2'd3;
    localparam int         N_ITEMS     = 1420;
    localparam int         CYCLE_LIMIT = 600000;

    typedef struct {
        logic [1:0]  func;
        logic [7:0]  offset;
        logic [15:0] wdata;
        logic [15:0] avail;
        bit          hold;
    } bus_item_t;

    typedef struct packed {
        logic [15:0] rdata;
        logic        irq_level;
        logic        irq_pulse;
        logic [11:0] dest;
        logic [15:0] words;
        logic [6:0]  pages;
        logic [11:0] daram;
    } dma_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = FUNC_READ;
    logic [7:0]  offset = '0;
    logic [15:0] wdata = '0;
    logic [15:0] rx_avail_words = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] rdata;
    logic        irq_level;
    logic        irq_pulse;
    logic [11:0] xfer_dest_index;
    logic [15:0] xfer_words;
    logic [6:0]  xfer_pages;
    logic [11:0] daram_word;

    // register bank model
    logic [5:0]  bank_cfg;
    logic [3:0]  bank_owner;
    logic [15:0] bank_paddr [CHANNELS];
    logic [10:0] bank_pdepth [CHANNELS];
    logic [11:0] bank_api [CHANNELS];
    logic [11:0] bank_plen [CHANNELS];
    logic [12:0] bank_ctrl [CHANNELS];
    logic [11:0] bank_coff [CHANNELS];

    bus_item_t   pending [$];
    dma_result_t expected_results [$];
    int          n_total;
    int          n_acc = 0;
    int          n_got = 0;
    int          errors = 0;
    int          cycles = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    bit          tail_calm = 1'b0;

    four_channel_dma_register_bank_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .offset          (offset),
        .wdata           (wdata),
        .rx_avail_words  (rx_avail_words),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .rdata           (rdata),
        .irq_level       (irq_level),
        .irq_pulse       (irq_pulse),
        .xfer_dest_index (xfer_dest_index),
        .xfer_words      (xfer_words),
        .xfer_pages      (xfer_pages),
        .daram_word      (daram_word)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    function automatic logic [7:0] ch_off(int ch, logic [3:0] sub);
        return 8'(16 + 16 * ch + int'(sub));
    endfunction

    function automatic dma_result_t bank_step(bus_item_t it);
        dma_result_t r;
        logic [3:0]  sub;
        logic [12:0] c;
        int          ch;
        int unsigned maxw, dst, total, np, rem, got;
        r = '0;
        sub = it.offset[3:0];
        ch = -1;
        if (it.offset >= 8'h10 && ((int'(it.offset) - 16) >> 4) < CHANNELS)
            ch = (int'(it.offset) - 16) >> 4;
        case (it.func)
            FUNC_READ:
            begin
                if (it.offset == OFF_CFG)
                    r.rdata = 16'(bank_cfg);
                else if (it.offset == OFF_OWNER)
                    r.rdata = 16'(bank_owner);
                else if (ch >= 0)
                begin
                    case (sub)
                        SUB_PADDR:  r.rdata = bank_paddr[ch];
                        SUB_PDEPTH: r.rdata = 16'(bank_pdepth[ch]);
                        SUB_API:    r.rdata = 16'(bank_api[ch]);
                        SUB_PLEN:   r.rdata = 16'(bank_plen[ch]);
                        SUB_CTRL:
                        begin
                            r.rdata = 16'(bank_ctrl[ch] & ~C_START);
                            bank_ctrl[ch] = bank_ctrl[ch] & ~(C_IRQSTATE | C_ERROR);
                        end
                        SUB_COFF:   r.rdata = 16'(bank_coff[ch]);
                        default:    r.rdata = '0;
                    endcase
                end
            end
            FUNC_WRITE:
            begin
                if (it.offset == OFF_CFG)
                    bank_cfg = it.wdata[5:0];
                else if (it.offset == OFF_OWNER)
                    bank_owner = it.wdata[3:0];
                else if (ch >= 0)
                begin
                    case (sub)
                        SUB_PADDR:  bank_paddr[ch] = it.wdata;
                        SUB_PDEPTH: bank_pdepth[ch] = it.wdata[10:0];
                        SUB_API:    bank_api[ch] = it.wdata[11:0];
                        SUB_PLEN:   bank_plen[ch] = it.wdata[11:0];
                        SUB_CTRL:
                            bank_ctrl[ch] = (it.wdata[12:0] & ~C_RO) | (bank_ctrl[ch] & C_RO);
                        default: ;
                    endcase
                end
            end
            FUNC_RX:
            begin
                c = bank_ctrl[RX_CH];
                if ((c & C_ENABLE) != 0 && (c & C_DIR) != 0)
                begin
                    maxw = bank_plen[RX_CH] / 2;
                    dst = bank_api[RX_CH] / 2;
                    if (maxw == 0 || dst >= API_WORDS)
                        bank_ctrl[RX_CH] = bank_ctrl[RX_CH] | C_ERROR;
                    else
                    begin
                        if (dst + maxw > API_WORDS)
                            maxw = API_WORDS - dst;
                        rem = it.avail;
                        total = 0;
                        np = 0;
                        // a short page empties the receiver, so the loop ends there
                        while (rem != 0 && np < MAX_PAGES)
                        begin
                            got = rem < maxw ? rem : maxw;
                            rem -= got;
                            total += got;
                            np++;
                            bank_coff[RX_CH] = 12'(got * 2);
                            bank_ctrl[RX_CH] = bank_ctrl[RX_CH] ^ C_PAGE;
                        end
                        if (total != 0)
                        begin
                            c = (bank_ctrl[RX_CH] | C_IRQSTATE | C_IDLE) & ~C_START;
                            if ((c & C_ONESHOT) != 0)
                                c = c & ~C_ENABLE;
                            bank_ctrl[RX_CH] = c;
                            r.dest = 12'(dst);
                            r.words = 16'(total);
                            r.pages = np > 127 ? 7'd127 : 7'(np);
                            r.irq_pulse = (c & C_IRQMODE) != 0;
                        end
                    end
                end
            end
            default: ;
        endcase
        for (int i = 0; i < CHANNELS; i++)
            if ((bank_ctrl[i] & C_IRQSTATE) != 0)
                r.irq_level = 1'b1;
        if (bank_api[RX_CH] != 0)
            r.daram = DARAM_BASE + 12'(bank_api[RX_CH][11:1]);
        return r;
    endfunction

    task automatic add_item(logic [1:0] f, logic [7:0] off, logic [15:0] wd = '0,
                            logic [15:0] av = '0, bit hold = 1'b0);
        pending.push_back('{f, off, wd, av, hold});
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        bit took;
        bit show;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func <= FUNC_READ;
            offset <= '0;
            wdata <= '0;
            rx_avail_words <= '0;
            n_acc <= 0;
            tail_calm <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            took = in_valid && !in_stall;
            if (took)
                expected_results.push_back(bank_step(pending.pop_front()));
            show = in_valid && !took;
            if (!show && pending.size() != 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending[0].hold && n_got != n_acc + int'(took))
                    show = 1'b0;
                else if (!tail_calm && (n_acc / 100) % 3 != 2 && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(0, 8);
                else
                    show = 1'b1;
            end
            in_valid <= show;
            if (show)
            begin
                func <= pending[0].func;
                offset <= pending[0].offset;
                wdata <= pending[0].wdata;
                rx_avail_words <= pending[0].avail;
            end
            n_acc <= n_acc + int'(took);
            tail_calm <= pending.size() < 150;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        dma_result_t seen;
        dma_result_t want;
        bit          stall_nxt;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            n_got <= 0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = {rdata, irq_level, irq_pulse, xfer_dest_index, xfer_words,
                        xfer_pages, daram_word};
                if (expected_results.size() == 0)
                begin
                    if (errors < 10)
                        $display("result %0d with no item pending: rdata=%h lvl=%b pulse=%b",
                                 n_got, seen.rdata, seen.irq_level, seen.irq_pulse);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (seen !== want)
                    begin
                        if (errors < 10)
                        begin
                            $display("result %0d expected: rdata=%h lvl=%b pulse=%b dest=%h words=%h pages=%0d daram=%h",
                                     n_got, want.rdata, want.irq_level, want.irq_pulse,
                                     want.dest, want.words, want.pages, want.daram);
                            $display("result %0d actual:   rdata=%h lvl=%b pulse=%b dest=%h words=%h pages=%0d daram=%h",
                                     n_got, seen.rdata, seen.irq_level, seen.irq_pulse,
                                     seen.dest, seen.words, seen.pages, seen.daram);
                        end
                        errors++;
                    end
                end
                n_got <= n_got + 1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                stall_nxt = 1'b1;
            end
            else if (!tail_calm && (n_got / 100) % 3 != 1 && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                stall_nxt = 1'b1;
            end
            else
                stall_nxt = 1'b0;
            out_stall <= stall_nxt;
        end
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int n_rx;
        bank_cfg = CFG_RESET;
        bank_owner = OWNER_RESET;
        for (int i = 0; i < CHANNELS; i++)
        begin
            bank_paddr[i] = '0;
            bank_pdepth[i] = '0;
            bank_api[i] = '0;
            bank_plen[i] = '0;
            bank_ctrl[i] = CTRL_INIT_VAL;
            bank_coff[i] = '0;
        end

        // reset values, masks and unmapped space
        add_item(FUNC_READ, OFF_CFG);
        add_item(FUNC_READ, OFF_OWNER);
        add_item(FUNC_READ, ch_off(RX_CH, SUB_CTRL));
        add_item(FUNC_WRITE, OFF_CFG, 16'hFFFF);
        add_item(FUNC_WRITE, OFF_OWNER, 16'hFFFF);
        add_item(FUNC_READ, OFF_CFG);
        add_item(FUNC_NOP, 8'hFF, 16'hFFFF, 16'hFFFF);
        add_item(FUNC_WRITE, 8'h21, 16'hFFFF);
        add_item(FUNC_READ, 8'h21);
        add_item(FUNC_WRITE, ch_off(CHANNELS, SUB_PADDR), 16'hFFFF);
        add_item(FUNC_READ, ch_off(CHANNELS, SUB_PADDR));
        // receive while disabled, then with zero page length
        add_item(FUNC_RX, OFF_CFG, '0, 16'd10);
        add_item(FUNC_WRITE, ch_off(RX_CH, SUB_CTRL), 16'hFFFF);
        add_item(FUNC_RX, OFF_CFG, '0, 16'd5);
        add_item(FUNC_READ, ch_off(RX_CH, SUB_CTRL));
        // page cap with a two-word page at the highest destination index, one-shot
        add_item(FUNC_WRITE, ch_off(RX_CH, SUB_PLEN), 16'd4);
        add_item(FUNC_WRITE, ch_off(RX_CH, SUB_API), 16'hFFFF);
        add_item(FUNC_RX, OFF_CFG, '0, 16'hFFFF);
        add_item(FUNC_RX, OFF_CFG, '0, 16'hFFFF);
        // empty receiver, short last page, read-only offset
        add_item(FUNC_WRITE, ch_off(RX_CH, SUB_CTRL), 16'(C_ENABLE | C_DIR));
        add_item(FUNC_RX, OFF_CFG, '0, 16'd0);
        add_item(FUNC_RX, OFF_CFG, '0, 16'd3);
        add_item(FUNC_WRITE, ch_off(RX_CH, SUB_COFF), 16'hFFFF);
        add_item(FUNC_READ, ch_off(RX_CH, SUB_COFF));
        add_item(FUNC_WRITE, ch_off(RX_CH, SUB_API), 16'h0000);
        add_item(FUNC_READ, ch_off(RX_CH, SUB_CTRL));

        while (pending.size() < N_ITEMS)
        begin
            if ($urandom_range(0, 99) < 65)
            begin
                add_item(FUNC_WRITE, ch_off(RX_CH, SUB_PLEN),
                         $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 80)),
                         16'($urandom), $urandom_range(0, 9) == 0);
                add_item(FUNC_WRITE, ch_off(RX_CH, SUB_API),
                         $urandom_range(0, 7) == 0 ? 16'h0000 : 16'($urandom));
                add_item(FUNC_WRITE, ch_off(RX_CH, SUB_CTRL),
                         $urandom_range(0, 9) != 0 ? 16'($urandom) | 16'(C_ENABLE | C_DIR)
                                                   : 16'($urandom));
                n_rx = $urandom_range(1, 3);
                for (int k = 0; k < n_rx; k++)
                    add_item(FUNC_RX, 8'($urandom), 16'($urandom),
                             $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                       : 16'($urandom_range(0, 300)));
                add_item(FUNC_READ, ch_off(RX_CH, SUB_CTRL));
                add_item(FUNC_READ, ch_off(RX_CH, SUB_COFF));
            end
            else if ($urandom_range(0, 5) == 0)
                add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                         16'($urandom), 16'($urandom));
            else if ($urandom_range(0, 1) == 0)
                add_item(2'($urandom_range(0, 3)),
                         ch_off($urandom_range(0, CHANNELS), 4'($urandom_range(0, 7) * 2)),
                         16'($urandom), 16'($urandom));
            else
                add_item(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                         16'($urandom));
        end
        n_total = pending.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (n_acc == n_total);
        wait (n_got == n_acc);
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
